/* sv/polyphase_stereo_resampler_top_defines.svh */
`ifndef POLYPHASE_STEREO_RESAMPLER_TOP_DEFINES_SVH
`define POLYPHASE_STEREO_RESAMPLER_TOP_DEFINES_SVH

// concurrent check on the rising clock edge, idle while reset is high
`define PSR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds during reset
`define PSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/psr_pkg.sv */
`timescale 1ns / 1ps
package psr_pkg;

   localparam int HALF_TAPS_DEF   = 32;
   localparam int PHASE_COUNT_DEF = 256;
   localparam int RING_DEPTH_DEF  = 128;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int RATIO_W  = 28;
   localparam int FRAC_W   = 24;
   localparam int POS_W    = 32;
   localparam int INDEX_W  = 15;
   localparam int ACTION_W = 2;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 28'h100_0000;

   // pipeline depth from tap issue to accumulator update
   localparam int DRAIN_CYCLES = 4;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH    = 2'd0,
      ACT_PULL    = 2'd1,
      ACT_LOAD    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PREP,
      ST_BASE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic issue;
      logic acc_clear;
   } tap_ctl_type;

endpackage

/* sv/psr_channels.sv */
`timescale 1ns / 1ps
interface psr_req_if
   import psr_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;
   logic [INDEX_W-1:0]         coef_index;
   logic signed [COEF_W-1:0]   coef_value;

   modport source (output valid, action, left_in, right_in, coef_index, coef_value,
                   input ready);
   modport sink   (input valid, action, left_in, right_in, coef_index, coef_value,
                   output ready);
endinterface

interface psr_rsp_if
   import psr_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic                       sample_valid;
   logic                       needs_input;

   modport source (output valid, left_out, right_out, sample_valid, needs_input,
                   input ready);
   modport sink   (input valid, left_out, right_out, sample_valid, needs_input,
                   output ready);
endinterface

interface psr_csr_if
   import psr_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [RATIO_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* sv/psr_coef.sv */
`timescale 1ns / 1ps
module psr_coef
   import psr_pkg::*;
#(
   parameter int COEF_SIZE = (PHASE_COUNT_DEF + 1) * 2 * HALF_TAPS_DEF,
   parameter int TAP_COUNT = 2 * HALF_TAPS_DEF,
   parameter int CA_W      = $clog2(COEF_SIZE)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CA_W-1:0]          wr_addr,
   input  logic signed [COEF_W-1:0] wr_data,
   input  logic                     issue,
   input  logic [CA_W-1:0]          rd_addr,
   input  logic [FRAC_W-1:0]        blend_t,
   output logic                     w_valid,
   output logic signed [COEF_W-1:0] w
);

   logic signed [COEF_W-1:0] coef_mem [COEF_SIZE];

   logic [CA_W-1:0]          next_row_addr;
   logic signed [COEF_W-1:0] a_ff, b_ff, a2_ff, w_ff;
   logic signed [COEF_W:0]   diff;
   logic signed [43:0]       prod_in, prod_ff;
   logic signed [COEF_W+1:0] w_sum;
   logic                     v1_ff, v2_ff, v3_ff;

   assign next_row_addr = rd_addr + CA_W'(TAP_COUNT);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_addr] <= wr_data;
      end
      a_ff <= coef_mem[rd_addr];
      b_ff <= coef_mem[next_row_addr];
   end

   assign diff    = (COEF_W+1)'(b_ff) - (COEF_W+1)'(a_ff);
   assign prod_in = 44'(diff) * 44'($signed({1'b0, blend_t}));
   // arithmetic shift gives the floor of the scaled difference
   assign w_sum   = (COEF_W+2)'(a2_ff) + (COEF_W+2)'(prod_ff >>> FRAC_W);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a2_ff   <= a_ff;
      w_ff    <= COEF_W'(w_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign w_valid = v3_ff;
   assign w       = w_ff;

endmodule

/* sv/psr_lane.sv */
`timescale 1ns / 1ps
module psr_lane
   import psr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int RA_W       = $clog2(RING_DEPTH),
   parameter int ACC_W      = 41
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [RA_W-1:0]            wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic [RA_W-1:0]            rd_addr,
   input  tap_ctl_type                ctl,
   input  logic                       w_valid,
   input  logic signed [COEF_W-1:0]   w,
   output logic signed [ACC_W-1:0]    acc
);

   logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
   logic signed [SAMPLE_W-1:0] s1_ff, s2_ff, s3_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [COEF_W+SAMPLE_W-1:0] prod;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[wr_addr] <= wr_data;
      end
      if (ctl.issue) begin
         s1_ff <= ring[rd_addr];
      end
   end

   // sample delayed to line up with the blended tap
   always_ff @(posedge clock) begin
      s2_ff <= s1_ff;
      s3_ff <= s2_ff;
   end

   assign prod = (COEF_W+SAMPLE_W)'(w) * (COEF_W+SAMPLE_W)'(s3_ff);

   always_ff @(posedge clock) begin
      if (ctl.acc_clear) begin
         acc_ff <= '0;
      end else if (w_valid) begin
         acc_ff <= acc_ff + ACC_W'(prod);
      end
   end

   assign acc = acc_ff;

endmodule

/* sv/psr_merge.sv */
`timescale 1ns / 1ps
module psr_merge
   import psr_pkg::*;
#(
   parameter int ACC_W = 41
) (
   input  logic signed [ACC_W-1:0]    acc_left,
   input  logic signed [ACC_W-1:0]    acc_right,
   output logic signed [SAMPLE_W-1:0] left,
   output logic signed [SAMPLE_W-1:0] right
);

   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] x
   );
      logic signed [ACC_W:0] r;
      logic signed [ACC_W:0] sh;
      r  = (ACC_W+1)'(x) + (ACC_W+1)'(32768);
      sh = r >>> 16;
      if (sh > $signed((ACC_W+1)'(32767))) begin
         return 16'sh7fff;
      end else if (sh < -$signed((ACC_W+1)'(32768))) begin
         return 16'sh8000;
      end
      return SAMPLE_W'(sh);
   endfunction

   assign left  = round_sat(acc_left);
   assign right = round_sat(acc_right);

endmodule

/* sv/polyphase_stereo_resampler_top.sv */
`timescale 1ns / 1ps
// Stereo polyphase resampler. Every request gives exactly one response. A pull
// makes one multiply-accumulate pass over the taps, one tap per cycle, with the
// left and right lanes working side by side on a shared blended coefficient.
// Restart, and reset, sweep both sample rings to silence while no request is taken;
// the rate register can be written at any time the block is idle. Coefficients must
// be loaded before a pull reads them. The response register frees the request side
// while a result waits.
module polyphase_stereo_resampler_top
   import psr_pkg::*;
#(
   parameter int HALF_TAPS   = HALF_TAPS_DEF,
   parameter int PHASE_COUNT = PHASE_COUNT_DEF,
   parameter int RING_DEPTH  = RING_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   psr_req_if.sink  req_bus,
   psr_rsp_if.source rsp_bus,
   psr_csr_if.sink  csr_bus
);

   localparam int TAP_COUNT = 2 * HALF_TAPS;
   localparam int COEF_SIZE = (PHASE_COUNT + 1) * TAP_COUNT;
   localparam int CA_W      = $clog2(COEF_SIZE);
   localparam int RA_W      = $clog2(RING_DEPTH);
   localparam int SX        = RA_W + 3;
   localparam int JW        = $clog2(TAP_COUNT);
   localparam int PH_W      = $clog2(PHASE_COUNT);
   localparam int U_W       = FRAC_W + $clog2(PHASE_COUNT + 1);
   localparam int ACC_W     = COEF_W + SAMPLE_W + $clog2(TAP_COUNT) + 1;
   // slot correction when a 32-bit count wraps
   localparam int WRAP_ADJ  = RING_DEPTH - int'(64'h1_0000_0000 % 64'(RING_DEPTH));
   localparam int WC_SLOT   = HALF_TAPS % RING_DEPTH;

   function automatic logic [RA_W-1:0] slot_reduce(input logic [SX-1:0] x);
      logic [SX-1:0] v;
      v = x;
      for (int k = 0; k < 3; k++) begin
         if (v >= SX'(RING_DEPTH)) begin
            v = v - SX'(RING_DEPTH);
         end
      end
      return v[RA_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [RATIO_W-1:0]  ratio_ff;
   logic [POS_W-1:0]    pos_ff, wc_ff;
   logic [FRAC_W-1:0]   frac_ff, t_ff;
   logic [RA_W-1:0]     wslot_ff, rslot_ff, tslot_ff, clr_ff;
   logic [JW-1:0]       j_ff;
   logic [DRAIN_W-1:0]  drain_ff;
   logic [PH_W-1:0]     p_ff;
   logic [CA_W-1:0]     base_ff;
   action_type          act_ff, act_in;
   logic                resp_pend_ff;
   logic signed [SAMPLE_W-1:0] res_l_ff, res_r_ff;

   logic                rsp_valid_ff, rsp_sv_ff, rsp_need_ff;
   logic signed [SAMPLE_W-1:0] rsp_l_ff, rsp_r_ff;

   logic                accept, rsp_free, in_range, needs_now;
   logic [POS_W-1:0]    diff;
   logic [U_W-1:0]      u;
   logic [FRAC_W:0]     frac_sum;
   logic [4:0]          pos_inc;
   logic [POS_W:0]      pos_next;

   logic                ring_we, coef_we;
   logic [RA_W-1:0]     ring_wa;
   logic signed [SAMPLE_W-1:0] ring_wl, ring_wr;
   logic [CA_W-1:0]     coef_wa, coef_ra;
   logic [31:0]         idx32;
   tap_ctl_type         ctl;
   logic                w_valid;
   logic signed [COEF_W-1:0] w;
   logic signed [ACC_W-1:0]  acc_l, acc_r;
   logic signed [SAMPLE_W-1:0] mrg_l, mrg_r;

   assign act_in    = action_type'(req_bus.action);
   assign accept    = req_bus.valid && req_bus.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign idx32     = 32'(req_bus.coef_index);
   assign in_range  = idx32 < 32'(COEF_SIZE);
   assign diff      = wc_ff - pos_ff - 32'(TAP_COUNT);
   assign needs_now = (diff == '0) || diff[POS_W-1];
   assign u         = U_W'(frac_ff) * U_W'(PHASE_COUNT);
   assign frac_sum  = {1'b0, frac_ff} + {1'b0, ratio_ff[FRAC_W-1:0]};
   assign pos_inc   = {1'b0, ratio_ff[RATIO_W-1:FRAC_W]} + 5'(frac_sum[FRAC_W]);
   assign pos_next  = {1'b0, pos_ff} + (POS_W+1)'(pos_inc);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (act_in)
                  ACT_PULL:    state_in = ST_PREP;
                  ACT_RESTART: state_in = ST_CLEAR;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_ff == RA_W'(RING_DEPTH - 1)) begin
               state_in = resp_pend_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_PREP:   state_in = ST_BASE;
         ST_BASE:   state_in = ST_MAC;
         ST_MAC: begin
            if (j_ff == JW'(TAP_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE);
      ctl.issue     = (state_ff == ST_MAC);
      ctl.acc_clear = (state_ff == ST_BASE);
      ring_we       = 1'b0;
      ring_wa       = wslot_ff;
      ring_wl       = req_bus.left_in;
      ring_wr       = req_bus.right_in;
      coef_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ring_we = accept && (act_in == ACT_PUSH);
            coef_we = accept && (act_in == ACT_LOAD) && in_range;
         end
         ST_CLEAR: begin
            ring_we = 1'b1;
            ring_wa = clr_ff;
            ring_wl = '0;
            ring_wr = '0;
         end
         default: ;
      endcase
   end

   assign coef_wa = idx32[CA_W-1:0];
   assign coef_ra = base_ff + CA_W'(j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         ratio_ff <= csr_bus.data;
      end
   end

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frac_ff      <= '0;
         wc_ff        <= POS_W'(HALF_TAPS);
         wslot_ff     <= RA_W'(WC_SLOT);
         rslot_ff     <= '0;
         clr_ff       <= '0;
         resp_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         act_ff       <= ACT_PUSH;
      end else begin
         // a new result may load in the same cycle the old one transfers
         if (state_ff == ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  act_ff <= act_in;
                  case (act_in)
                     ACT_PUSH: begin
                        wc_ff    <= wc_ff + 32'd1;
                        wslot_ff <= slot_reduce(SX'(wslot_ff) + SX'(1) +
                                    ((wc_ff == '1) ? SX'(WRAP_ADJ) : SX'(0)));
                     end
                     ACT_RESTART: begin
                        pos_ff       <= '0;
                        frac_ff      <= '0;
                        wc_ff        <= POS_W'(HALF_TAPS);
                        wslot_ff     <= RA_W'(WC_SLOT);
                        rslot_ff     <= '0;
                        clr_ff       <= '0;
                        resp_pend_ff <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            ST_CLEAR: clr_ff <= clr_ff + RA_W'(1);
            ST_PREP: begin
               t_ff <= u[FRAC_W-1:0];
               p_ff <= u[FRAC_W +: PH_W];
            end
            ST_BASE: begin
               base_ff  <= CA_W'(p_ff) * CA_W'(TAP_COUNT);
               tslot_ff <= (rslot_ff == RA_W'(RING_DEPTH - 1)) ? '0 : rslot_ff + RA_W'(1);
               j_ff     <= '0;
            end
            ST_MAC: begin
               j_ff     <= j_ff + JW'(1);
               tslot_ff <= (tslot_ff == RA_W'(RING_DEPTH - 1)) ? '0 : tslot_ff + RA_W'(1);
               drain_ff <= '0;
            end
            ST_DRAIN: drain_ff <= drain_ff + DRAIN_W'(1);
            ST_FINISH: begin
               res_l_ff <= mrg_l;
               res_r_ff <= mrg_r;
               frac_ff  <= frac_sum[FRAC_W-1:0];
               pos_ff   <= pos_next[POS_W-1:0];
               rslot_ff <= slot_reduce(SX'(rslot_ff) + SX'(pos_inc) +
                           (pos_next[POS_W] ? SX'(WRAP_ADJ) : SX'(0)));
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_sv_ff    <= (act_ff == ACT_PULL);
                  rsp_l_ff     <= (act_ff == ACT_PULL) ? res_l_ff : '0;
                  rsp_r_ff     <= (act_ff == ACT_PULL) ? res_r_ff : '0;
                  rsp_need_ff  <= needs_now;
                  resp_pend_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.left_out     = rsp_l_ff;
   assign rsp_bus.right_out    = rsp_r_ff;
   assign rsp_bus.sample_valid = rsp_sv_ff;
   assign rsp_bus.needs_input  = rsp_need_ff;

   psr_coef #(
      .COEF_SIZE (COEF_SIZE),
      .TAP_COUNT (TAP_COUNT),
      .CA_W      (CA_W)
   ) u_coef (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_we),
      .wr_addr (coef_wa),
      .wr_data (req_bus.coef_value),
      .issue   (ctl.issue),
      .rd_addr (coef_ra),
      .blend_t (t_ff),
      .w_valid (w_valid),
      .w       (w)
   );

   psr_lane #(
      .RING_DEPTH (RING_DEPTH),
      .RA_W       (RA_W),
      .ACC_W      (ACC_W)
   ) u_lane_left (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (ring_wl),
      .rd_addr (tslot_ff),
      .ctl     (ctl),
      .w_valid (w_valid),
      .w       (w),
      .acc     (acc_l)
   );

   psr_lane #(
      .RING_DEPTH (RING_DEPTH),
      .RA_W       (RA_W),
      .ACC_W      (ACC_W)
   ) u_lane_right (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (ring_wr),
      .rd_addr (tslot_ff),
      .ctl     (ctl),
      .w_valid (w_valid),
      .w       (w),
      .acc     (acc_r)
   );

   psr_merge #(
      .ACC_W (ACC_W)
   ) u_merge (
      .acc_left  (acc_l),
      .acc_right (acc_r),
      .left      (mrg_l),
      .right     (mrg_r)
   );

endmodule

/* sv/psr_checker.sv */
`timescale 1ns / 1ps
`include "polyphase_stereo_resampler_top_defines.svh"
module psr_checker
   import psr_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_left,
   input logic signed [SAMPLE_W-1:0] rsp_right,
   input logic                       rsp_sample_valid
);

   // a stalled response keeps its payload
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left) && $stable(rsp_right) &&
         $stable(rsp_sample_valid);
   endproperty

   // only a pull carries sample data
   property p_zero_out;
      rsp_valid && !rsp_sample_valid |-> rsp_left == '0 && rsp_right == '0;
   endproperty

   // one request at a time: a transfer makes the block busy
   property p_busy;
      req_valid && req_ready |=> !req_ready;
   endproperty

   // reset leaves no response pending and the request side closed for the sweep
   property p_reset_quiet;
      reset |=> !rsp_valid && !req_ready;
   endproperty

   `PSR_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "response changed while stalled")
   `PSR_ASSERT(a_zero_out, clock, reset, p_zero_out, "non-pull response carries samples")
   `PSR_ASSERT(a_busy, clock, reset, p_busy, "request taken while busy")
   `PSR_ASSERT_ALWAYS(a_reset_quiet, clock, p_reset_quiet, "block active after reset")

endmodule

bind polyphase_stereo_resampler_top psr_checker u_psr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_left         (rsp_bus.left_out),
   .rsp_right        (rsp_bus.right_out),
   .rsp_sample_valid (rsp_bus.sample_valid)
);
